// ===== rtl/core/ocb_pkg.sv =====
// ----------------------------------------------------------------------------
// ocb_pkg
// Shared types, constants and command codes of the orbit camera basis block.
// ----------------------------------------------------------------------------
package ocb_pkg;

    // Beat widths on the stream channels
    localparam int unsigned IN_W  = 120;
    localparam int unsigned OUT_W = 240;

    // Angle constants, 1/128 degree
    localparam logic [15:0] QUARTER_TURN = 16'd11520;
    localparam logic [15:0] HALF_TURN    = 16'd23040;
    localparam logic [15:0] FULL_TURN    = 16'd46080;

    // Reset values of state and registers
    localparam logic [13:0] PITCH_LIMIT_RESET = 14'd8960;
    localparam logic [15:0] BOOM_RESET        = 16'd640;
    localparam logic [15:0] YAW_RESET         = 16'hD300;  // -11520

    // Configuration register indexes
    localparam logic [1:0] REG_PITCH_LIMIT = 2'd0;
    localparam logic [1:0] REG_BOOM        = 2'd1;

    // Reciprocal of a quarter turn: t = (r * TMUL_K) >> 20 gives floor(r * 2^28 / 11520)
    localparam longint unsigned TMUL_K_FULL = ((64'd1 << 48) + 64'd11519) / 64'd11520;
    localparam logic [34:0]     TMUL_K      = 35'(TMUL_K_FULL);

    // Odd Taylor coefficients of sin(pi/2 * t), Q28
    localparam logic [28:0] SC1 = 29'd421657428;
    localparam logic [28:0] SC3 = 29'd173399667;
    localparam logic [28:0] SC5 = 29'd21392326;
    localparam logic [28:0] SC7 = 29'd1256749;
    localparam logic [28:0] SC9 = 29'd43068;

    // Datapath operations
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_RED  = 4'd2;
    localparam logic [3:0] OP_TMUL = 4'd3;
    localparam logic [3:0] OP_SQ   = 4'd4;
    localparam logic [3:0] OP_HORN = 4'd5;
    localparam logic [3:0] OP_FIN  = 4'd6;
    localparam logic [3:0] OP_PROD = 4'd7;
    localparam logic [3:0] OP_OUT  = 4'd8;

    // Angle slots
    localparam logic [1:0] ANG_CP = 2'd0;
    localparam logic [1:0] ANG_SP = 2'd1;
    localparam logic [1:0] ANG_CY = 2'd2;
    localparam logic [1:0] ANG_SY = 2'd3;

    // Product steps
    localparam logic [2:0] PR_DX  = 3'd0;
    localparam logic [2:0] PR_DZ  = 3'd1;
    localparam logic [2:0] PR_UX  = 3'd2;
    localparam logic [2:0] PR_UZ  = 3'd3;
    localparam logic [2:0] PR_OX  = 3'd4;
    localparam logic [2:0] PR_OY  = 3'd5;
    localparam logic [2:0] PR_OZ  = 3'd6;
    localparam logic [2:0] PR_CAM = 3'd7;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    // Horner coefficient for step k, highest order first
    function automatic logic [28:0] horner_coef(input logic [1:0] k);
        logic [28:0] c;
        unique case (k)
            2'd0: c = SC7;
            2'd1: c = SC5;
            2'd2: c = SC3;
            2'd3: c = SC1;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/ocb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ocb_ctrl
// Sequencer: steps the datapath through angle update, four sine evaluations,
// the basis and camera products, and the output register load.
// ----------------------------------------------------------------------------
module ocb_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output ocb_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_TMUL = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_HORN = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_PROD = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_ang, n_ang;
    logic [2:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and command
    always_comb begin
        n_state   = r_state;
        n_ang     = r_ang;
        n_cnt     = r_cnt;
        o_cmd.op  = ocb_pkg::OP_NONE;
        o_cmd.idx = 3'd0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ocb_pkg::OP_LOAD;
                    n_ang    = ocb_pkg::ANG_CP;
                    n_state  = S_RED;
                end
            end
            S_RED: begin
                o_cmd.op  = ocb_pkg::OP_RED;
                o_cmd.idx = {1'b0, r_ang};
                n_state   = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.op = ocb_pkg::OP_TMUL;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = ocb_pkg::OP_SQ;
                n_cnt    = 3'd0;
                n_state  = S_HORN;
            end
            S_HORN: begin
                o_cmd.op  = ocb_pkg::OP_HORN;
                o_cmd.idx = r_cnt;
                if (r_cnt == 3'd3) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_FIN: begin
                o_cmd.op  = ocb_pkg::OP_FIN;
                o_cmd.idx = {1'b0, r_ang};
                if (r_ang == ocb_pkg::ANG_SY) begin
                    n_cnt   = ocb_pkg::PR_DX;
                    n_state = S_PROD;
                end else begin
                    n_ang   = r_ang + 2'd1;
                    n_state = S_RED;
                end
            end
            S_PROD: begin
                o_cmd.op  = ocb_pkg::OP_PROD;
                o_cmd.idx = r_cnt;
                if (r_cnt == ocb_pkg::PR_CAM) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = ocb_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output beat valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.op == ocb_pkg::OP_OUT) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ang       <= 2'd0;
            r_cnt       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ang       <= n_ang;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/ocb_dp.sv =====
// ----------------------------------------------------------------------------
// ocb_dp
// Datapath: angle state, configuration registers, shared Horner multiplier
// for the sine polynomial, shared signed multiplier for the basis and camera.
// ----------------------------------------------------------------------------
module ocb_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ocb_pkg::t_cmd                i_cmd,
    input  ocb_pkg::t_cfg_wr             i_cfg,
    input  logic [ocb_pkg::IN_W-1:0]     i_in_data,
    output logic [ocb_pkg::OUT_W-1:0]    o_out_data
);

    // Configuration and angle state
    logic        [13:0] r_limit;
    logic        [15:0] r_boom;
    logic signed [14:0] r_pitch;
    logic signed [15:0] r_yaw;

    // Item payload and working registers
    logic signed [31:0] r_ax, r_ay, r_az;
    logic        [13:0] r_rf;
    logic               r_neg;
    logic        [28:0] r_t, r_t2, r_s;
    logic signed [15:0] r_cp, r_sp, r_cy, r_sy;
    logic signed [15:0] r_dx, r_dz, r_ux, r_uz;
    logic signed [24:0] r_ox, r_oy, r_oz;
    logic        [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic [ocb_pkg::OUT_W-1:0] r_out;

    // Saturating camera subtract
    function automatic logic [31:0] sat_sub(input logic signed [31:0] a,
                                            input logic signed [24:0] o);
        logic signed [32:0] d;
        d = 33'(a) - 33'(o);
        if (d[32] != d[31]) begin
            return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return d[31:0];
    endfunction

    // Pitch and yaw update
    logic signed [11:0] w_pstep, w_ystep;
    logic signed [15:0] w_np;
    logic        [15:0] w_mag;
    logic               w_pitch_ok;
    logic signed [16:0] w_ny_sum, w_ny;

    assign w_pstep    = i_in_data[11:0];
    assign w_ystep    = i_in_data[23:12];
    assign w_np       = {r_pitch[14], r_pitch} + {{4{w_pstep[11]}}, w_pstep};
    assign w_mag      = w_np[15] ? 16'(-w_np) : w_np;
    assign w_pitch_ok = (w_mag < {2'b00, r_limit});
    assign w_ny_sum   = {r_yaw[15], r_yaw} + {{5{w_ystep[11]}}, w_ystep};

    always_comb begin
        priority if (w_ny_sum >= $signed({1'b0, ocb_pkg::HALF_TURN})) begin
            w_ny = w_ny_sum - $signed({1'b0, ocb_pkg::FULL_TURN});
        end else if (w_ny_sum < -$signed({1'b0, ocb_pkg::HALF_TURN})) begin
            w_ny = w_ny_sum + $signed({1'b0, ocb_pkg::FULL_TURN});
        end else begin
            w_ny = w_ny_sum;
        end
    end

    // Angle reduction to a first-quadrant remainder
    logic signed [16:0] w_ang;
    logic        [15:0] w_a;
    logic        [1:0]  w_q;
    logic        [15:0] w_r;
    logic        [13:0] w_rf;

    always_comb begin
        unique case (i_cmd.idx[1:0])
            ocb_pkg::ANG_CP: w_ang = {{2{r_pitch[14]}}, r_pitch}
                                     + $signed({1'b0, ocb_pkg::QUARTER_TURN});
            ocb_pkg::ANG_SP: w_ang = {{2{r_pitch[14]}}, r_pitch};
            ocb_pkg::ANG_CY: w_ang = {r_yaw[15], r_yaw}
                                     + $signed({1'b0, ocb_pkg::QUARTER_TURN});
            ocb_pkg::ANG_SY: w_ang = {r_yaw[15], r_yaw};
        endcase
        w_a = w_ang[16] ? 16'(w_ang + $signed({1'b0, ocb_pkg::FULL_TURN})) : w_ang[15:0];
        priority if (w_a < ocb_pkg::QUARTER_TURN) begin
            w_q = 2'd0;
            w_r = w_a;
        end else if (w_a < ocb_pkg::HALF_TURN) begin
            w_q = 2'd1;
            w_r = w_a - ocb_pkg::QUARTER_TURN;
        end else if (w_a < ocb_pkg::HALF_TURN + ocb_pkg::QUARTER_TURN) begin
            w_q = 2'd2;
            w_r = w_a - ocb_pkg::HALF_TURN;
        end else begin
            w_q = 2'd3;
            w_r = w_a - ocb_pkg::HALF_TURN - ocb_pkg::QUARTER_TURN;
        end
        w_rf = w_q[0] ? 14'(ocb_pkg::QUARTER_TURN - w_r) : w_r[13:0];
    end

    // Remainder to Q28 fraction of a quarter turn
    logic [48:0] w_tprod;
    assign w_tprod = 49'(r_rf) * 49'(ocb_pkg::TMUL_K);

    // Shared Horner multiplier
    logic [28:0] w_ha, w_hb;
    logic [57:0] w_hprod;
    logic [28:0] w_hsh;
    logic [29:0] w_vadd;
    logic [15:0] w_vq, w_vcap;
    logic signed [15:0] w_sine;

    always_comb begin
        unique case (i_cmd.op)
            ocb_pkg::OP_SQ:   begin w_ha = r_t;  w_hb = r_t; end
            ocb_pkg::OP_HORN: begin w_ha = r_t2; w_hb = r_s; end
            default:          begin w_ha = r_t;  w_hb = r_s; end
        endcase
    end

    assign w_hprod = 58'(w_ha) * 58'(w_hb);
    assign w_hsh   = w_hprod[56:28];
    assign w_vadd  = 30'(w_hsh) + 30'd8192;
    assign w_vq    = w_vadd[29:14];
    assign w_vcap  = (w_vq > 16'd16384) ? 16'd16384 : w_vq;
    assign w_sine  = r_neg ? -$signed(w_vcap) : $signed(w_vcap);

    // Shared signed multiplier for basis and camera offsets
    logic signed [16:0] w_pa, w_pb;
    logic signed [33:0] w_pprod;
    logic signed [33:0] w_r14, w_r6;
    logic signed [15:0] w_q14;
    logic signed [24:0] w_off;

    always_comb begin
        unique case (i_cmd.idx)
            ocb_pkg::PR_DX: begin w_pa = 17'(r_cy); w_pb = 17'(r_cp); end
            ocb_pkg::PR_DZ: begin w_pa = 17'(r_sy); w_pb = 17'(r_cp); end
            ocb_pkg::PR_UX: begin w_pa = 17'(r_sp); w_pb = 17'(r_cy); end
            ocb_pkg::PR_UZ: begin w_pa = 17'(r_sp); w_pb = 17'(r_sy); end
            ocb_pkg::PR_OX: begin w_pa = 17'(r_dx); w_pb = $signed({1'b0, r_boom}); end
            ocb_pkg::PR_OY: begin w_pa = 17'(r_sp); w_pb = $signed({1'b0, r_boom}); end
            ocb_pkg::PR_OZ: begin w_pa = 17'(r_dz); w_pb = $signed({1'b0, r_boom}); end
            default:        begin w_pa = 17'(r_dx); w_pb = 17'(r_dz); end
        endcase
    end

    // Round to nearest, ties away from zero: (p + half - neg) >>> n
    assign w_pprod = 34'(w_pa) * 34'(w_pb);
    assign w_r14   = w_pprod + 34'sd8192 - 34'(w_pprod[33]);
    assign w_r6    = w_pprod + 34'sd32 - 34'(w_pprod[33]);
    assign w_q14   = w_r14[29:14];
    assign w_off   = w_r6[30:6];

    // Basis signs follow the sign of the pitch cosine
    logic               w_flip;
    logic signed [15:0] w_rx, w_rz, w_uy;
    assign w_flip = r_cp[15];
    assign w_rx   = w_flip ? -r_sy : r_sy;
    assign w_rz   = w_flip ? r_cy : -r_cy;
    assign w_uy   = w_flip ? -r_cp : r_cp;

    // Configuration and angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ocb_pkg::PITCH_LIMIT_RESET;
            r_boom  <= ocb_pkg::BOOM_RESET;
            r_pitch <= 15'sd0;
            r_yaw   <= ocb_pkg::YAW_RESET;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    ocb_pkg::REG_PITCH_LIMIT: r_limit <= i_cfg.data[13:0];
                    ocb_pkg::REG_BOOM:        r_boom  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.op == ocb_pkg::OP_LOAD) begin
                if (w_pitch_ok) begin
                    r_pitch <= w_np[14:0];
                end
                r_yaw <= w_ny[15:0];
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ocb_pkg::OP_LOAD: begin
                r_ax <= i_in_data[55:24];
                r_ay <= i_in_data[87:56];
                r_az <= i_in_data[119:88];
            end
            ocb_pkg::OP_RED: begin
                r_rf  <= w_rf;
                r_neg <= w_q[1];
            end
            ocb_pkg::OP_TMUL: r_t <= w_tprod[48:20];
            ocb_pkg::OP_SQ: begin
                r_t2 <= w_hsh;
                r_s  <= ocb_pkg::SC9;
            end
            ocb_pkg::OP_HORN: r_s <= ocb_pkg::horner_coef(i_cmd.idx[1:0]) - w_hsh;
            ocb_pkg::OP_FIN: begin
                unique case (i_cmd.idx[1:0])
                    ocb_pkg::ANG_CP: r_cp <= w_sine;
                    ocb_pkg::ANG_SP: r_sp <= w_sine;
                    ocb_pkg::ANG_CY: r_cy <= w_sine;
                    ocb_pkg::ANG_SY: r_sy <= w_sine;
                endcase
            end
            ocb_pkg::OP_PROD: begin
                unique case (i_cmd.idx)
                    ocb_pkg::PR_DX: r_dx <= w_q14;
                    ocb_pkg::PR_DZ: r_dz <= w_q14;
                    ocb_pkg::PR_UX: r_ux <= w_flip ? w_q14 : -w_q14;
                    ocb_pkg::PR_UZ: r_uz <= w_flip ? w_q14 : -w_q14;
                    ocb_pkg::PR_OX: r_ox <= w_off;
                    ocb_pkg::PR_OY: r_oy <= w_off;
                    ocb_pkg::PR_OZ: r_oz <= w_off;
                    default: begin
                        r_cam_x <= sat_sub(r_ax, r_ox);
                        r_cam_y <= sat_sub(r_ay, r_oy);
                        r_cam_z <= sat_sub(r_az, r_oz);
                    end
                endcase
            end
            ocb_pkg::OP_OUT: begin
                r_out <= {r_cam_z, r_cam_y, r_cam_x, r_uz, w_uy, r_ux,
                          w_rz, 16'd0, w_rx, r_dz, r_sp, r_dx};
            end
            default: ;
        endcase
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/core/orbit_camera_basis.sv =====
// ----------------------------------------------------------------------------
// orbit_camera_basis
// Yaw/pitch orbit camera: view, right and up vectors and boom camera position.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*): one beat per camera update, carrying the pitch and
//   yaw steps and the followed actor position. Master stream (m_axis_*): one
//   beat per input beat with the direction, right and up vectors (Q2.14) and
//   the camera position (Q16.16, saturated).
//   Configuration channel (i_cfg_*): index 0 pitch limit, index 1 boom
//   distance; always ready. The user must see that it is written only while
//   no item is in flight; the block itself does not enforce this. A new
//   input is accepted only once the previous result sits in the output
//   register. Each item passes the shared sine unit: four evaluations of
//   eight steps each (reduce, scale, square, four Horner steps, finish), then
//   eight steps on the shared product multiplier and one output load.
//   Reset: pitch 0, yaw -90 degrees, limit 70 degrees, boom 2.5; no beat out.
//   Stall: a stalled result beat holds; the next item is still taken and
//   worked on, and waits at the output load until the held beat is taken.
// ----------------------------------------------------------------------------
module orbit_camera_basis (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // pitch_step[11:0], yaw_step[23:12], actor_x[55:24], actor_y[87:56],
    // actor_z[119:88]
    input  logic [119:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dir_x[15:0], dir_y[31:16], dir_z[47:32], right_x[63:48],
    // right_y[79:64], right_z[95:80], up_x[111:96], up_y[127:112],
    // up_z[143:128], cam_x[175:144], cam_y[207:176], cam_z[239:208]
    output logic [239:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    ocb_pkg::t_cmd    w_cmd;
    ocb_pkg::t_cfg_wr w_cfg;

    // Configuration writes are taken every cycle
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    ocb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    ocb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (w_cfg),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

endmodule

// ===== rtl/core/ocb_checker.sv =====
// ----------------------------------------------------------------------------
// ocb_checker
// Port-level checks on the result stream of the orbit camera basis.
// ----------------------------------------------------------------------------
module ocb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic [239:0] m_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready
);

    // Hold a stalled beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // No beat straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // Right vector lies in the horizontal plane
    a_right_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:64] == 16'd0)
        else $error("right_y not zero");

    // Up vector never points down
    a_up_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[127])
        else $error("up_y negative");

endmodule

bind orbit_camera_basis ocb_checker u_ocb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
